/* design/htfd_pkg.sv */
// Shared types, constants and the CRC-8 byte step of the sensor frame decoder.
`default_nettype none
package htfd_pkg;

  localparam int unsigned RAW_W    = 20;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned PAYLOAD_W = 2 * RAW_W;

  localparam logic [2:0] FRAME_LAST_POS = 3'd6;
  localparam logic [7:0] CRC_POLY       = 8'h31;
  localparam logic [7:0] CRC_INIT       = 8'hFF;
  localparam int unsigned BUSY_BIT      = 7;

  localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } frame_status_t;

  // A checked frame on its way from the tracker to the scaler.
  typedef struct packed {
    frame_status_t    status;
    logic [RAW_W-1:0] raw_humidity;
    logic [RAW_W-1:0] raw_temperature;
  } frame_t;

  // CRC-8, MSB first, no reflection, over one byte.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/htfd_byte_if.sv */
// Channel that carries received frame bytes into the decoder.
`default_nettype none
interface htfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface
`default_nettype wire

/* design/htfd_result_if.sv */
// Channel that carries decoded frame results out of the decoder.
`default_nettype none
interface htfd_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          frame_status;
  logic [htfd_pkg::RAW_W-1:0]          raw_humidity;
  logic [htfd_pkg::RAW_W-1:0]          raw_temperature;
  logic [htfd_pkg::HUM_W-1:0]          humidity_centi;
  logic signed [htfd_pkg::TEMP_W-1:0]  temperature_centi;

  modport source (output valid, output frame_status, output raw_humidity,
                  output raw_temperature, output humidity_centi,
                  output temperature_centi, input ready);
  modport sink   (input valid, input frame_status, input raw_humidity,
                  input raw_temperature, input humidity_centi,
                  input temperature_centi, output ready);
endinterface
`default_nettype wire

/* design/htfd_frame_tracker.sv */
// Byte counter, running CRC and payload capture; emits one checked frame per seven bytes.
`default_nettype none
module htfd_frame_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_ready,
  input  wire logic [7:0]       data_byte,
  input  wire logic             frame_start,
  output logic                  frame_valid,
  output htfd_pkg::frame_t      frame,
  input  wire logic             frame_take
);

  logic [2:0]                          pos;
  logic [7:0]                          crc;
  logic                                busy_seen;
  logic [htfd_pkg::PAYLOAD_W-1:0]      payload;

  logic                                accept;
  logic [2:0]                          pos_eff;
  logic [7:0]                          crc_eff;
  logic                                last_byte;
  htfd_pkg::frame_t                    frame_next;

  assign byte_ready = !frame_valid || frame_take;
  assign accept     = byte_valid && byte_ready;

  // A start mark, or a count that cannot occur, begins a fresh frame with this item.
  assign pos_eff   = (frame_start || pos > htfd_pkg::FRAME_LAST_POS) ? 3'd0 : pos;
  assign crc_eff   = (frame_start || pos > htfd_pkg::FRAME_LAST_POS) ? htfd_pkg::CRC_INIT : crc;
  assign last_byte = (pos_eff == htfd_pkg::FRAME_LAST_POS);

  always_comb begin
    frame_next.status          = htfd_pkg::STATUS_OK;
    frame_next.raw_humidity    = '0;
    frame_next.raw_temperature = '0;
    priority if (busy_seen) begin
      frame_next.status = htfd_pkg::STATUS_BUSY;
    end else if (data_byte != crc_eff) begin
      frame_next.status = htfd_pkg::STATUS_CRC_ERR;
    end else begin
      frame_next.raw_humidity    = payload[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W];
      frame_next.raw_temperature = payload[htfd_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 3'd0;
      crc         <= htfd_pkg::CRC_INIT;
      busy_seen   <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (accept && !last_byte) begin
        if (pos_eff == 3'd0) begin
          busy_seen <= data_byte[htfd_pkg::BUSY_BIT];
        end
        crc <= htfd_pkg::crc_step(crc_eff, data_byte);
        pos <= pos_eff + 3'd1;
      end else if (accept) begin
        crc <= htfd_pkg::CRC_INIT;
        pos <= 3'd0;
      end

      if (accept && last_byte) begin
        frame_valid <= 1'b1;
      end else if (frame_take) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_byte && pos_eff != 3'd0) begin
      payload <= {payload[htfd_pkg::PAYLOAD_W-9:0], data_byte};
    end
    if (accept && last_byte) begin
      frame <= frame_next;
    end
  end

endmodule
`default_nettype wire

/* design/htfd_scaler.sv */
// Scales the raw codes to hundredths and holds the result item for the output channel.
`default_nettype none
module htfd_scaler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          frame_valid,
  input  htfd_pkg::frame_t                   frame,
  output logic                               frame_take,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic [1:0]                         frame_status,
  output logic [htfd_pkg::RAW_W-1:0]         raw_humidity,
  output logic [htfd_pkg::RAW_W-1:0]         raw_temperature,
  output logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi
);

  localparam int unsigned HUM_PROD_W  = htfd_pkg::RAW_W + htfd_pkg::HUM_W;
  localparam int unsigned TEMP_PROD_W = htfd_pkg::RAW_W + htfd_pkg::TEMP_W;

  logic [HUM_PROD_W-1:0]         hum_prod;
  logic [TEMP_PROD_W-1:0]        temp_prod;
  logic [htfd_pkg::TEMP_W-1:0]   temp_scaled;
  logic [htfd_pkg::HUM_W-1:0]    hum_next;
  logic [htfd_pkg::TEMP_W-1:0]   temp_next;
  logic                          frame_ok;

  assign frame_take = !result_valid || result_ready;
  assign frame_ok   = (frame.status == htfd_pkg::STATUS_OK);

  // The shift by the code width keeps the floor of each product.
  assign hum_prod    = HUM_PROD_W'(frame.raw_humidity) * HUM_PROD_W'(htfd_pkg::HUM_SCALE);
  assign temp_prod   = TEMP_PROD_W'(frame.raw_temperature) * TEMP_PROD_W'(htfd_pkg::TEMP_SCALE);
  assign temp_scaled = temp_prod[TEMP_PROD_W-1:htfd_pkg::RAW_W];

  // Rejected frames report every value as zero, including the temperature.
  assign hum_next  = frame_ok ? hum_prod[HUM_PROD_W-1:htfd_pkg::RAW_W] : '0;
  assign temp_next = frame_ok ? (temp_scaled - htfd_pkg::TEMP_OFFSET) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_take) begin
      result_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take && frame_valid) begin
      frame_status      <= frame.status;
      raw_humidity      <= frame.raw_humidity;
      raw_temperature   <= frame.raw_temperature;
      humidity_centi    <= hum_next;
      temperature_centi <= $signed(temp_next);
    end
  end

endmodule
`default_nettype wire

/* design/humidity_temp_frame_decoder.sv */
// Sensor frame decoder: CRC-checked seven-byte frames in, scaled readings out.
// After its CRC byte, a result passes the frame register and then the result register.
// Throughput: one byte per cycle, each stage advancing only when the next one is free.
// The frame register and the result register part the two channels.
// Reset clears the byte count, the CRC to its initial value and both valid flags.
`default_nettype none
module humidity_temp_frame_decoder (
  input wire logic      clk,
  input wire logic      rst,
  htfd_byte_if.sink     frame_bytes,
  htfd_result_if.source results
);

  logic             frame_valid;
  logic             frame_take;
  htfd_pkg::frame_t frame;

  htfd_frame_tracker tracker (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (frame_bytes.valid),
    .byte_ready  (frame_bytes.ready),
    .data_byte   (frame_bytes.data_byte),
    .frame_start (frame_bytes.frame_start),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_take  (frame_take)
  );

  htfd_scaler scaler (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame             (frame),
    .frame_take        (frame_take),
    .result_valid      (results.valid),
    .result_ready      (results.ready),
    .frame_status      (results.frame_status),
    .raw_humidity      (results.raw_humidity),
    .raw_temperature   (results.raw_temperature),
    .humidity_centi    (results.humidity_centi),
    .temperature_centi (results.temperature_centi)
  );

endmodule
`default_nettype wire

/* design/htfd_checker.sv */
// Port-level checks of the sensor frame decoder, bound to its top level.
`default_nettype none
module htfd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [1:0]                          frame_status,
  input wire logic [htfd_pkg::RAW_W-1:0]          raw_humidity,
  input wire logic [htfd_pkg::RAW_W-1:0]          raw_temperature,
  input wire logic [htfd_pkg::HUM_W-1:0]          humidity_centi,
  input wire logic signed [htfd_pkg::TEMP_W-1:0]  temperature_centi
);

  // No result item may appear in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(frame_status)
                                 && $stable(humidity_centi))
    else $error("stalled result item changed or vanished");

  // A rejected frame carries no readings at all.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_status != htfd_pkg::STATUS_OK |->
        raw_humidity == '0 && raw_temperature == '0 &&
        humidity_centi == '0 && temperature_centi == '0)
    else $error("rejected frame carries readings");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_status == htfd_pkg::STATUS_OK |->
        humidity_centi <= 14'd9999 && temperature_centi >= -15'sd5000 &&
        temperature_centi <= 15'sd14999)
    else $error("scaled reading out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker checker_inst (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .frame_status      (results.frame_status),
  .raw_humidity      (results.raw_humidity),
  .raw_temperature   (results.raw_temperature),
  .humidity_centi    (results.humidity_centi),
  .temperature_centi (results.temperature_centi)
);
`default_nettype wire

/* test/testbench.sv */
// Testbench for the sensor frame decoder: byte stream in, checked and scaled readings out.
`timescale 1ns / 1ps
module testbench;

  localparam int STIMULUS_BYTES = 1880;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_AT_CYCLE  = 1500;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    htfd_pkg::frame_status_t                status;
    logic [htfd_pkg::RAW_W-1:0]             raw_hum;
    logic [htfd_pkg::RAW_W-1:0]             raw_temp;
    logic [htfd_pkg::HUM_W-1:0]             hum_centi;
    logic signed [htfd_pkg::TEMP_W-1:0]     temp_centi;
  } reading_t;

  // Tracks the frame as the decoder should see it and keeps the readings still owed.
  class frame_scoreboard;
    logic [2:0]                     byte_pos;
    logic [7:0]                     crc_acc;
    logic                           busy_flag;
    logic [htfd_pkg::PAYLOAD_W-1:0] payload;
    reading_t                       pending_readings[$];
    int unsigned                    mismatches;

    function new();
      byte_pos   = '0;
      crc_acc    = htfd_pkg::CRC_INIT;
      busy_flag  = 1'b0;
      payload    = '0;
      mismatches = 0;
    endfunction

    // Bitwise form: each data bit is folded into the top of the register.
    static function logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function void note_byte(input logic [7:0] b, input logic s);
      reading_t    r;
      logic [33:0] hum_prod;
      logic [34:0] temp_prod;
      if (s || byte_pos > htfd_pkg::FRAME_LAST_POS) begin
        byte_pos = '0;
        crc_acc  = htfd_pkg::CRC_INIT;
      end
      if (byte_pos < htfd_pkg::FRAME_LAST_POS) begin
        if (byte_pos == '0) begin
          busy_flag = b[htfd_pkg::BUSY_BIT];
        end else begin
          payload = {payload[htfd_pkg::PAYLOAD_W-9:0], b};
        end
        crc_acc  = crc8_update(crc_acc, b);
        byte_pos = byte_pos + 3'd1;
      end else begin
        r = '0;
        if (busy_flag) begin
          r.status = htfd_pkg::STATUS_BUSY;
        end else if (b != crc_acc) begin
          r.status = htfd_pkg::STATUS_CRC_ERR;
        end else begin
          r.status     = htfd_pkg::STATUS_OK;
          r.raw_hum    = payload[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W];
          r.raw_temp   = payload[htfd_pkg::RAW_W-1:0];
          hum_prod     = r.raw_hum * 34'd10000;
          temp_prod    = r.raw_temp * 35'd20000;
          r.hum_centi  = hum_prod[33:20];
          r.temp_centi = temp_prod[34:20] - 15'd5000;
        end
        pending_readings.push_back(r);
        byte_pos = '0;
        crc_acc  = htfd_pkg::CRC_INIT;
      end
    endfunction

    function void check_reading(input reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected reading status %0d rh %h rt %h hc %0d tc %0d", $time,
                   got.status, got.raw_hum, got.raw_temp, got.hum_centi, got.temp_centi);
        end
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (got.status != want.status || got.raw_hum != want.raw_hum ||
            got.raw_temp != want.raw_temp || got.hum_centi != want.hum_centi ||
            got.temp_centi != want.temp_centi) begin
          if (mismatches < 10) begin
            $display("%0t: reading mismatch", $time);
            $display("  expected status %0d rh %h rt %h hc %0d tc %0d", want.status,
                     want.raw_hum, want.raw_temp, want.hum_centi, want.temp_centi);
            $display("  actual   status %0d rh %h rt %h hc %0d tc %0d", got.status,
                     got.raw_hum, got.raw_temp, got.hum_centi, got.temp_centi);
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  htfd_byte_if   frame_bytes();
  htfd_result_if frame_results();

  humidity_temp_frame_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .results     (frame_results)
  );

  frame_scoreboard sb;
  int bytes_sent   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;

  always #1 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_byte(input logic [7:0] b, input logic s);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        frame_bytes.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    frame_bytes.valid       <= 1'b1;
    frame_bytes.data_byte   <= b;
    frame_bytes.frame_start <= s;
    @(posedge clk);
    while (!frame_bytes.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] status,
                            input logic [htfd_pkg::PAYLOAD_W-1:0] pl,
                            input bit crc_good, input bit with_start, input int count);
    logic [7:0] frame [7];
    logic [7:0] crc;
    crc      = htfd_pkg::CRC_INIT;
    frame[0] = status;
    for (int i = 1; i <= 5; i++) frame[i] = pl[47 - 8 * i -: 8];
    for (int i = 0; i <= 5; i++) crc = frame_scoreboard::crc8_update(crc, frame[i]);
    frame[6] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < count; i++) offer_byte(frame[i], (i == 0) && with_start);
  endtask

  initial begin
    int                             kind;
    int                             pick;
    logic [7:0]                     st;
    logic [htfd_pkg::PAYLOAD_W-1:0] pl;
    sb = new();
    rst = 1'b1;
    frame_bytes.valid       = 1'b0;
    frame_bytes.data_byte   = '0;
    frame_bytes.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A partial frame cut short by a restart, then zero and full-scale readings, the second
    // relying on the wrap after the CRC byte, then busy with a bad CRC and a plain bad CRC.
    send_frame(8'h80, {$urandom, 8'($urandom)}, 1'b1, 1'b1, 2);
    send_frame(8'h00, '0, 1'b1, 1'b1, 7);
    send_frame(8'h7F, '1, 1'b1, 1'b0, 7);
    send_frame(8'hFF, {$urandom, 8'($urandom)}, 1'b0, 1'b1, 7);
    send_frame(8'h18, {$urandom, 8'($urandom)}, 1'b0, 1'b0, 7);

    while (bytes_sent < STIMULUS_BYTES) begin
      kind = $urandom_range(0, 99);
      st   = 8'($urandom);
      st[htfd_pkg::BUSY_BIT] = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < 5; k++) begin
        pick = $urandom_range(0, 7);
        pl   = {pl[htfd_pkg::PAYLOAD_W-9:0],
                (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom)};
      end
      if (kind < 8) begin
        repeat ($urandom_range(1, 6)) offer_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else if (kind < 16) begin
        send_frame(st, pl, 1'b1, 1'b1, $urandom_range(1, 6));
      end else begin
        send_frame(st, pl, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0, 7);
      end
    end
    frame_bytes.valid <= 1'b0;

    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
      $display("[humidity_temp_frame_decoder] OK");
    end else begin
      $display("[humidity_temp_frame_decoder] ERROR");
    end
    $finish;
  end

  // The receiver switches among four ready habits and once holds off long enough
  // for the decoder to back up into its input.
  initial begin
    int cyc;
    int hold_left;
    int mode;
    cyc       = 0;
    hold_left = 0;
    mode      = 0;
    frame_results.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        frame_results.ready <= 1'b0;
      end else begin
        case (mode)
          0: frame_results.ready <= 1'b1;
          1: frame_results.ready <= ($urandom_range(0, 3) != 0);
          2: frame_results.ready <= ($urandom_range(0, 3) == 0);
          default: frame_results.ready <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor_blk
    reading_t got;
    if (!rst) begin
      if (frame_bytes.valid && frame_bytes.ready) begin
        sb.note_byte(frame_bytes.data_byte, frame_bytes.frame_start);
      end
      if (frame_results.valid && frame_results.ready) begin
        got.status     = htfd_pkg::frame_status_t'(frame_results.frame_status);
        got.raw_hum    = frame_results.raw_humidity;
        got.raw_temp   = frame_results.raw_temperature;
        got.hum_centi  = frame_results.humidity_centi;
        got.temp_centi = frame_results.temperature_centi;
        sb.check_reading(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_bytes.valid && frame_bytes.ready) ||
        (frame_results.valid && frame_results.ready)) begin
      stall_cycles = 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[humidity_temp_frame_decoder] ERROR");
      $finish;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
  end

endmodule
